FILE: rtl/core/pta_pkg.sv
// ============================================================================
// Peer table package
// Shared request/result types and codes for the aging peer table.
// ============================================================================
package pta_pkg;

    typedef enum logic [1:0] {
        REQ_TOUCH  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_SWEEP  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_FULL    = 3'd2,
        ST_FOUND   = 3'd3,
        ST_MISSING = 3'd4,
        ST_REMOVED = 3'd5,
        ST_DONE    = 3'd6,
        ST_SPARE   = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] peer_addr;
        logic [47:0] time_value;
        logic        attrs_complete;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] entry_addr;
        logic [47:0] entry_time;
        logic        turned_ready;
        logic        is_last;
    } rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_EXEC  = 2'd1,
        BK_SWEEP = 2'd2,
        BK_DONE  = 2'd3
    } bk_state_t;

endpackage

FILE: rtl/core/pta_front.sv
// ============================================================================
// Peer table front end
// Accept a request, drop unknown codes, and queue it for the back end.
// ============================================================================
module pta_front
    import pta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t cmd,
    input  logic pop,
    input  logic active,
    output logic busy,
    output logic q_valid,
    output req_t q_data
);

    logic q_valid_reg;
    logic q_valid_next;
    req_t q_data_reg;

    // Hold off new transfers while the queue is full or the back end works
    assign busy = q_valid_reg || active;

    // One-entry queue
    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (pop)
        begin
            q_valid_next = 1'b0;
        end
        if (start && !busy && (cmd.req_type != REQ_NONE))
        begin
            q_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            q_data_reg <= cmd;
        end
    end

    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;

endmodule

FILE: rtl/core/pta_back.sv
// ============================================================================
// Peer table back end
// Execute touch, lookup and aging sweep against the slot table.
// ============================================================================
module pta_back
    import pta_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  req_t q_data,
    output logic pop,
    output logic active,
    output logic rsp_valid,
    output rsp_t rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAXREP = 32;
    localparam int CW = $clog2(MAXREP + 1);

    logic [TABLE_DEPTH-1:0] used_reg;
    logic [TABLE_DEPTH-1:0] ready_reg;
    logic [47:0]            key_mem   [TABLE_DEPTH];
    logic [47:0]            stamp_mem [TABLE_DEPTH];

    bk_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic [TABLE_DEPTH-1:0] hit_vec;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [47:0]   wr_stamp;
    logic          sweep_kill;

    // Parallel key compare and free slot search
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_vec[i] = used_reg[i] && (key_mem[i] == q_data.peer_addr);
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign sweep_kill = (state_reg == BK_SWEEP) && used_reg[idx_reg]
                        && (stamp_mem[idx_reg] < q_data.time_value);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = hit_idx;
        wr_stamp       = q_data.time_value;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_data.req_type == REQ_SWEEP) ? BK_SWEEP : BK_EXEC;
                    idx_next   = '0;
                    cnt_next   = '0;
                end
            end
            BK_EXEC:
            begin
                pop            = 1'b1;
                state_next     = BK_IDLE;
                rsp_valid_next = 1'b1;
                rsp_next.entry_addr   = q_data.peer_addr;
                rsp_next.turned_ready = 1'b0;
                rsp_next.is_last      = 1'b1;
                if (q_data.req_type == REQ_LOOKUP)
                begin
                    rsp_next.status     = hit ? ST_FOUND : ST_MISSING;
                    rsp_next.entry_time = hit ? stamp_mem[hit_idx] : '0;
                end
                else if (hit)
                begin
                    wr_en = 1'b1;
                    rsp_next.status       = ST_UPDATED;
                    rsp_next.entry_time   = q_data.time_value;
                    rsp_next.turned_ready = !ready_reg[hit_idx] && q_data.attrs_complete;
                end
                else if (free_any)
                begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx;
                    rsp_next.status       = ST_ADDED;
                    rsp_next.entry_time   = q_data.time_value;
                    rsp_next.turned_ready = q_data.attrs_complete;
                end
                else
                begin
                    rsp_next.status     = ST_FULL;
                    rsp_next.entry_time = '0;
                end
            end
            BK_SWEEP:
            begin
                if (sweep_kill && ready_reg[idx_reg] && (cnt_reg < CW'(MAXREP)))
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status       = ST_REMOVED;
                    rsp_next.entry_addr   = key_mem[idx_reg];
                    rsp_next.entry_time   = stamp_mem[idx_reg];
                    rsp_next.turned_ready = 1'b0;
                    rsp_next.is_last      = 1'b0;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (idx_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_DONE:
            begin
                pop            = 1'b1;
                state_next     = BK_IDLE;
                rsp_valid_next = 1'b1;
                rsp_next.status       = ST_DONE;
                rsp_next.entry_addr   = '0;
                rsp_next.entry_time   = '0;
                rsp_next.turned_ready = 1'b0;
                rsp_next.is_last      = 1'b1;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            ready_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            // Apply touch or removal to slot flags
            if (wr_en)
            begin
                used_reg[wr_idx] <= 1'b1;
                if (wr_idx == free_idx && !hit)
                begin
                    ready_reg[wr_idx] <= q_data.attrs_complete;
                end
                else if (q_data.attrs_complete)
                begin
                    ready_reg[wr_idx] <= 1'b1;
                end
            end
            if (sweep_kill)
            begin
                used_reg[idx_reg]  <= 1'b0;
                ready_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Result register, key and stamp storage
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (wr_en)
        begin
            key_mem[wr_idx]   <= q_data.peer_addr;
            stamp_mem[wr_idx] <= wr_stamp;
        end
    end

    assign active    = (state_reg != BK_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/core/peer_table_with_aging_core.sv
// ============================================================================
// Peer table with aging
// Station table keyed by 48-bit address with touch, lookup and aging sweep.
// ============================================================================
// Touch and lookup pass the queue register, the compare-and-write state
// and the result register on the way to the result strobe; busy stays high
// meanwhile, so requests never overlap. A sweep walks one slot per cycle,
// strobing up to 32 removed ready entries as it goes, then a closing result.
// Results are strobed for one cycle and cannot be held.
module peer_table_with_aging_core
    import pta_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);

    logic q_valid;
    req_t q_data;
    logic pop;
    logic active;

    pta_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .pop     (pop),
        .active  (active),
        .busy    (busy),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    pta_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .active    (active),
        .rsp_valid (done),
        .rsp       (result)
    );

    // Hold off transfers while a request is queued or executing
    logic done_last;
    assign done_last = done && result.is_last;
    logic busy_int;
    assign busy_int = q_valid || active;

`ifndef SYNTHESIS
    a_pop_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop without queued request");
    a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> done_last)
        else $error("completed request gave no last result");
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        busy_int |-> busy)
        else $error("accepting while work pending");
`endif

endmodule

FILE: bench/tb_peer_table_with_aging_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Peer table with aging testbench
// Drives touch, lookup and sweep requests through the start/busy handshake,
// predicts every result from a behavioral copy of the table and checks each
// strobed result against the oldest prediction. Sender gaps vary by phase.
// ============================================================================
module tb_peer_table_with_aging_core;
    import pta_pkg::*;

    localparam int DEPTH = 32;
    localparam int MAX_RSP = 33;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    req_t cmd;
    logic busy;
    logic done;
    rsp_t result;

    peer_table_with_aging_core #(.TABLE_DEPTH(DEPTH)) u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Table shadow
    logic        tbl_used [DEPTH];
    logic [47:0] tbl_key [DEPTH];
    logic [47:0] tbl_stamp [DEPTH];
    logic        tbl_ready [DEPTH];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [47:0] known_addrs[$];

    int idle_pct;
    int mismatches;
    int rsp_count;
    int req_count;
    int removed_count;
    int cycles;

    function automatic rsp_t make_rsp(status_t st, logic [47:0] a, logic [47:0] t,
                                      logic rdy, logic last);
        rsp_t r;
        r.status = st;
        r.entry_addr = a;
        r.entry_time = t;
        r.turned_ready = rdy;
        r.is_last = last;
        return r;
    endfunction

    // Apply one request to the shadow table and queue its results
    task automatic predict_table(req_t rq);
        int hit;
        int free_slot;
        int n;
        status_t st;
        logic turned;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tbl_used[i] && tbl_key[i] == rq.peer_addr && hit < 0)
                hit = i;
            if (!tbl_used[i] && free_slot < 0)
                free_slot = i;
        end
        case (req_type_t'(rq.req_type))
            REQ_TOUCH:
            begin
                st = ST_UPDATED;
                turned = 1'b0;
                if (hit < 0)
                begin
                    if (free_slot < 0)
                    begin
                        expected_rsps.push_back(make_rsp(ST_FULL, rq.peer_addr, '0, 0, 1));
                        return;
                    end
                    hit = free_slot;
                    tbl_used[hit] = 1'b1;
                    tbl_key[hit] = rq.peer_addr;
                    tbl_ready[hit] = 1'b0;
                    st = ST_ADDED;
                end
                tbl_stamp[hit] = rq.time_value;
                if (!tbl_ready[hit] && rq.attrs_complete)
                begin
                    tbl_ready[hit] = 1'b1;
                    turned = 1'b1;
                end
                expected_rsps.push_back(make_rsp(st, rq.peer_addr, rq.time_value, turned, 1));
            end
            REQ_LOOKUP:
            begin
                if (hit < 0)
                    expected_rsps.push_back(make_rsp(ST_MISSING, rq.peer_addr, '0, 0, 1));
                else
                    expected_rsps.push_back(make_rsp(ST_FOUND, rq.peer_addr,
                                                     tbl_stamp[hit], 0, 1));
            end
            REQ_SWEEP:
            begin
                n = 0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (tbl_used[i] && tbl_stamp[i] < rq.time_value)
                    begin
                        if (tbl_ready[i] && n < MAX_RSP - 1)
                        begin
                            expected_rsps.push_back(make_rsp(ST_REMOVED, tbl_key[i],
                                                             tbl_stamp[i], 0, 0));
                            n++;
                        end
                        tbl_used[i] = 1'b0;
                        tbl_ready[i] = 1'b0;
                    end
                end
                expected_rsps.push_back(make_rsp(ST_DONE, '0, '0, 0, 1));
            end
            default:
            begin
                // unknown request: ignored
            end
        endcase
    endtask

    function automatic req_t make_req(req_type_t t, logic [47:0] a, logic [47:0] tv,
                                      logic ac);
        req_t r;
        r.req_type = t;
        r.peer_addr = a;
        r.time_value = tv;
        r.attrs_complete = ac;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // Pick an address: mostly from a small reused pool so hits happen
    function automatic logic [47:0] pick_addr();
        if (known_addrs.size() > 0 && $urandom_range(99, 0) < 70)
            return known_addrs[$urandom_range(known_addrs.size() - 1, 0)];
        return rand48();
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Track acceptance at the rising edge
    logic accepted;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accepted <= 1'b0;
        else
            accepted <= start && !busy;
    end

    // Driver: present items at the falling edge, hold until transferred
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else if (!start || accepted)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= idle_pct)
            begin
                cmd <= pending_reqs.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                cmd <= req_t'({$urandom(), $urandom(), $urandom(), $urandom()});
            end
        end
    end

    // Predict on each transfer
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_table(cmd);
            req_count++;
        end
    end

    // Monitor: check each strobed result
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            rsp_count++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (exp_rsp.status == ST_REMOVED)
                    removed_count++;
                if (result.status !== exp_rsp.status
                    || result.entry_addr !== exp_rsp.entry_addr
                    || result.entry_time !== exp_rsp.entry_time
                    || result.turned_ready !== exp_rsp.turned_ready
                    || result.is_last !== exp_rsp.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_rsp, result);
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    // Add a random item to the pending queue, well-formed mostly
    task automatic queue_random();
        int pick;
        req_t rq;
        pick = $urandom_range(99, 0);
        if (pick < 60)
        begin
            rq = make_req(REQ_TOUCH, pick_addr(), {40'd0, 8'($urandom())} << 8,
                          1'($urandom_range(1, 0)));
            if ($urandom_range(9, 0) == 0)
                rq.time_value = rand48();
            known_addrs.push_back(rq.peer_addr);
            if (known_addrs.size() > 40)
                void'(known_addrs.pop_front());
        end
        else if (pick < 85)
            rq = make_req(REQ_LOOKUP, pick_addr(), rand48(), 1'($urandom_range(1, 0)));
        else if (pick < 95)
            rq = make_req(REQ_SWEEP, rand48(), {40'd0, 8'($urandom())} << 8,
                          1'($urandom_range(1, 0)));
        else
            rq = make_req(REQ_NONE, rand48(), rand48(), 1'($urandom_range(1, 0)));
        pending_reqs.push_back(rq);
    endtask

    initial
    begin
        int phase_pct [4];
        phase_pct = '{0, 52, 0, 15};
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_stamp[i] = '0;
            tbl_ready[i] = 1'b0;
        end
        mismatches = 0;
        rsp_count = 0;
        req_count = 0;
        removed_count = 0;
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every request type, table full, ties, stickiness
        pending_reqs.push_back(make_req(REQ_LOOKUP, '0, '1, 1));
        pending_reqs.push_back(make_req(REQ_TOUCH, '0, '0, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, '1, '1, 1));
        pending_reqs.push_back(make_req(REQ_TOUCH, '0, 48'd100, 1));
        pending_reqs.push_back(make_req(REQ_TOUCH, '0, 48'd100, 0));
        pending_reqs.push_back(make_req(REQ_LOOKUP, '1, '0, 0));
        pending_reqs.push_back(make_req(REQ_NONE, '1, '1, 1));
        pending_reqs.push_back(make_req(REQ_SWEEP, '1, 48'd100, 1));
        pending_reqs.push_back(make_req(REQ_LOOKUP, '0, '0, 0));
        pending_reqs.push_back(make_req(REQ_SWEEP, '0, 48'd101, 0));
        pending_reqs.push_back(make_req(REQ_LOOKUP, '0, '0, 0));
        // Fill the table with ready entries, overflow, then sweep them all
        for (int i = 0; i < DEPTH; i++)
            pending_reqs.push_back(make_req(REQ_TOUCH, 48'h5a5a_0000_0000 + i,
                                            48'd10 + i, 1));
        pending_reqs.push_back(make_req(REQ_TOUCH, 48'h1234_5678_9abc, 48'd7, 1));
        pending_reqs.push_back(make_req(REQ_SWEEP, '0, '1, 0));
        pending_reqs.push_back(make_req(REQ_SWEEP, '0, '0, 0));
        wait_drained();

        // Random phases with different sender gaps
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int k = 0; k < 26; k++)
                queue_random();
            wait_drained();
        end
        idle_pct = 0;
        repeat (DEPTH + 10) @(posedge clk);

        $display("Ran %0d requests, checked %0d results (%0d aged-out entries).",
                 req_count, rsp_count, removed_count);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_rsps.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
